[sv/i2cmb_pkg.sv]
`default_nettype none

package i2cmb_pkg;

  localparam int RX_DEPTH_DEF = 32;

  localparam int FRAME_COPY_THRESHOLD = 17;
  localparam int SYNC_READ_LAST = 10;
  localparam int MGMT_READ_LAST = 1;
  localparam int SYNC_SNAP_LEN = 15;
  localparam int MGMT_SNAP_LEN = 2;
  localparam int COPY_LEN = SYNC_SNAP_LEN + MGMT_SNAP_LEN;
  localparam int COPY_IDX_W = $clog2(COPY_LEN);

  localparam logic [1:0] OP_ADDR_WRITE = 2'd0;
  localparam logic [1:0] OP_DATA_WRITE = 2'd1;
  localparam logic [1:0] OP_READ_REQ   = 2'd2;

  localparam logic [1:0] SRC_NONE = 2'd0;
  localparam logic [1:0] SRC_MGMT = 2'd1;
  localparam logic [1:0] SRC_SYNC = 2'd2;

  localparam logic [1:0] CFG_MASTER_ID_POS = 2'd0;
  localparam logic [1:0] CFG_MGMT_ID       = 2'd1;
  localparam logic [1:0] CFG_SYNC_ID       = 2'd2;

  typedef struct packed {
    logic store_byte;
    logic serve;
    logic id_check;
    logic copy_rd;
  } i2cmb_cmd_t;

  typedef struct packed {
    logic copy_start;
    logic copy_last;
    logic out_blocked;
  } i2cmb_status_t;

endpackage

`default_nettype wire

[sv/i2c_slave_frame_mailbox_unit.sv]
`default_nettype none

// Channel   Direction  Handshake           Payload
// in_       input      in_valid/in_stall   in_opcode[1:0], in_bus_byte[7:0]
// out_      output     out_valid/out_stall out_read_byte[7:0], out_source[1:0]
// cfg_      input      cfg_wr_en           cfg_index[1:0], cfg_wdata[7:0]
//
// Address writes and read requests need no further states; a read result sits in the output register.
// A data write passes through the store write, identifier read and compare, then the copy and
// drain states when a full frame is copied out of the receive store (one read a cycle).
// Synchronous reset clears all indices, mode, snapshots and the store valid bits.
// Every transaction stalls while a data write is still being checked or copied, and a read
// request also stalls while the previous result is still waiting.

module i2c_slave_frame_mailbox_unit
  import i2cmb_pkg::*;
#(
  parameter int RX_DEPTH = RX_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_wdata,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_opcode,
  input  wire logic [7:0] in_bus_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_read_byte,
  output logic [1:0]      out_source
);

  i2cmb_cmd_t    cmd;
  i2cmb_status_t status;

  i2cmb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_stall  (in_stall),
    .status    (status),
    .cmd       (cmd)
  );

  i2cmb_datapath #(
    .RX_DEPTH (RX_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_bus_byte   (in_bus_byte),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_read_byte (out_read_byte),
    .out_source    (out_source)
  );

endmodule

`default_nettype wire

[sv/i2cmb_ctrl.sv]
`default_nettype none

module i2cmb_ctrl
  import i2cmb_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic [1:0]    in_opcode,
  output logic               in_stall,
  input  wire i2cmb_status_t status,
  output i2cmb_cmd_t         cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ID_READ,
    ST_ID_CHECK,
    ST_COPY,
    ST_COPY_DRAIN
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign in_stall = (state_r != ST_IDLE) ||
                    ((in_opcode == OP_READ_REQ) && status.out_blocked);
  assign accept = in_valid && !in_stall;

  always_comb begin
    cmd            = '0;
    cmd.store_byte = accept && (in_opcode == OP_DATA_WRITE);
    cmd.serve      = accept && (in_opcode == OP_READ_REQ);
    cmd.id_check   = (state_r == ST_ID_CHECK);
    cmd.copy_rd    = (state_r == ST_COPY);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_opcode == OP_DATA_WRITE)) begin
          state_nxt = ST_ID_READ;
        end
      end
      ST_ID_READ: begin
        state_nxt = ST_ID_CHECK;
      end
      ST_ID_CHECK: begin
        state_nxt = status.copy_start ? ST_COPY : ST_IDLE;
      end
      ST_COPY: begin
        if (status.copy_last) begin
          state_nxt = ST_COPY_DRAIN;
        end
      end
      ST_COPY_DRAIN: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/i2cmb_datapath.sv]
`default_nettype none

module i2cmb_datapath
  import i2cmb_pkg::*;
#(
  parameter int RX_DEPTH = RX_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_wdata,
  input  wire logic [7:0] in_bus_byte,
  input  wire i2cmb_cmd_t cmd,
  output i2cmb_status_t   status,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_read_byte,
  output logic [1:0]      out_source
);

  localparam int AW  = $clog2(RX_DEPTH);
  localparam int WPW = $clog2(RX_DEPTH + 1);
  localparam int PW  = ((AW > 5) ? AW : 5) + 1;

  logic [7:0]            mem [RX_DEPTH];
  logic [RX_DEPTH-1:0]   mem_vld_r;
  logic [7:0]            rd_data_r;
  logic                  rd_vld_r;
  logic [AW-1:0]         rd_addr;
  logic                  rd_in_range;

  logic [4:0]            id_pos_r;
  logic [7:0]            mgmt_id_r;
  logic [7:0]            sync_id_r;

  logic [7:0]            sync_snap_r [SYNC_SNAP_LEN];
  logic [7:0]            mgmt_snap_r [MGMT_SNAP_LEN];

  logic [WPW-1:0]        write_pos_r;
  logic [WPW-1:0]        write_pos_nxt;
  logic [3:0]            read_pos_r;
  logic [3:0]            read_pos_nxt;
  logic [1:0]            mode_r;
  logic [1:0]            mode_nxt;

  logic [COPY_IDX_W-1:0] copy_idx_r;
  logic [COPY_IDX_W-1:0] copy_wr_idx_r;
  logic                  copy_wr_r;

  logic                  out_valid_r;
  logic [7:0]            out_byte_r;
  logic [1:0]            out_src_r;
  logic [7:0]            serve_byte;

  logic                  store_ok;
  logic [7:0]            id_byte;
  logic                  mgmt_match;
  logic                  sync_match;
  logic                  frame_full;
  logic [7:0]            copy_byte;

  assign store_ok    = write_pos_r < WPW'(RX_DEPTH);
  assign rd_in_range = PW'(id_pos_r) < PW'(RX_DEPTH);
  assign rd_addr     = cmd.copy_rd ? AW'(copy_idx_r + 1'b1) : AW'(id_pos_r);
  assign id_byte     = rd_vld_r ? rd_data_r : 8'd0;
  assign copy_byte   = id_byte;
  assign mgmt_match  = (id_byte == mgmt_id_r);
  assign sync_match  = (id_byte == sync_id_r);
  assign frame_full  = write_pos_r > WPW'(FRAME_COPY_THRESHOLD);

  assign status.copy_start  = mgmt_match && frame_full;
  assign status.copy_last   = copy_idx_r == COPY_IDX_W'(COPY_LEN - 1);
  assign status.out_blocked = out_valid_r && out_stall;

  assign out_valid     = out_valid_r;
  assign out_read_byte = out_byte_r;
  assign out_source    = out_src_r;

  always_ff @(posedge clk) begin
    if (cmd.store_byte && store_ok) begin
      mem[write_pos_r[AW-1:0]] <= in_bus_byte;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (cmd.store_byte && store_ok) begin
        mem_vld_r[write_pos_r[AW-1:0]] <= 1'b1;
      end
      if (cmd.copy_rd) begin
        rd_vld_r <= mem_vld_r[rd_addr];
      end else begin
        rd_vld_r <= rd_in_range ? mem_vld_r[rd_addr] : 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_pos_r  <= 5'd0;
      mgmt_id_r <= 8'd1;
      sync_id_r <= 8'd2;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_MASTER_ID_POS: id_pos_r  <= cfg_wdata[4:0];
        CFG_MGMT_ID:       mgmt_id_r <= cfg_wdata;
        CFG_SYNC_ID:       sync_id_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    serve_byte = 8'd0;
    case (mode_r)
      SRC_MGMT: begin
        serve_byte = mgmt_snap_r[(read_pos_r < 4'(MGMT_SNAP_LEN)) ? read_pos_r[0] : 1'b0];
      end
      SRC_SYNC: begin
        serve_byte = sync_snap_r[(read_pos_r < 4'(SYNC_SNAP_LEN)) ? read_pos_r : 4'd0];
      end
      default: begin
        serve_byte = 8'd0;
      end
    endcase
  end

  always_comb begin
    write_pos_nxt = write_pos_r;
    read_pos_nxt  = read_pos_r;
    mode_nxt      = mode_r;
    if (cmd.store_byte && store_ok) begin
      write_pos_nxt = write_pos_r + 1'b1;
    end
    if (cmd.id_check) begin
      if (mgmt_match) begin
        mode_nxt     = SRC_MGMT;
        read_pos_nxt = 4'd0;
        if (frame_full) begin
          write_pos_nxt = '0;
        end
      end
      if (sync_match) begin
        mode_nxt      = SRC_SYNC;
        read_pos_nxt  = 4'd0;
        write_pos_nxt = '0;
      end
    end
    if (cmd.serve) begin
      case (mode_r)
        SRC_MGMT: begin
          write_pos_nxt = '0;
          read_pos_nxt  = (read_pos_r >= 4'(MGMT_READ_LAST)) ? 4'd0 : read_pos_r + 4'd1;
        end
        SRC_SYNC: begin
          write_pos_nxt = '0;
          read_pos_nxt  = (read_pos_r >= 4'(SYNC_READ_LAST)) ? 4'd0 : read_pos_r + 4'd1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_pos_r   <= '0;
      read_pos_r    <= 4'd0;
      mode_r        <= SRC_NONE;
      copy_idx_r    <= '0;
      copy_wr_r     <= 1'b0;
      copy_wr_idx_r <= '0;
      out_valid_r   <= 1'b0;
      for (int i = 0; i < SYNC_SNAP_LEN; i++) begin
        sync_snap_r[i] <= 8'd0;
      end
      for (int i = 0; i < MGMT_SNAP_LEN; i++) begin
        mgmt_snap_r[i] <= 8'd0;
      end
    end else begin
      write_pos_r   <= write_pos_nxt;
      read_pos_r    <= read_pos_nxt;
      mode_r        <= mode_nxt;
      copy_wr_r     <= cmd.copy_rd;
      copy_wr_idx_r <= copy_idx_r;
      if (cmd.copy_rd) begin
        copy_idx_r <= status.copy_last ? '0 : copy_idx_r + 1'b1;
      end
      if (copy_wr_r) begin
        if (copy_wr_idx_r < COPY_IDX_W'(SYNC_SNAP_LEN)) begin
          sync_snap_r[copy_wr_idx_r[3:0]] <= copy_byte;
        end else begin
          mgmt_snap_r[1'(copy_wr_idx_r - COPY_IDX_W'(SYNC_SNAP_LEN))] <= copy_byte;
        end
      end
      if (cmd.serve) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.serve) begin
      out_byte_r <= serve_byte;
      out_src_r  <= (mode_r == SRC_MGMT || mode_r == SRC_SYNC) ? mode_r : SRC_NONE;
    end
  end

endmodule

`default_nettype wire
